// ===== rtl/key_event_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Key event detector assertion macros
// Concurrent assertion shorthands clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef KEY_EVENT_DETECTOR_MACROS_SVH
`define KEY_EVENT_DETECTOR_MACROS_SVH

// Expression must hold at every edge outside reset.
`define KED_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ked_pkg.sv =====
// ----------------------------------------------------------------------------
// Key event detector package
// Field widths, command codes and tick conversion constants.
// ----------------------------------------------------------------------------
package ked_pkg;

  localparam int CMD_W  = 4;
  localparam int KEY_W  = 8;
  localparam int DUR_W  = 16;

  // One tick in milliseconds and the fixed double click window.
  localparam int TICK_MS          = 10;
  localparam int DOUBLE_WINDOW_MS = 500;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK          = 4'd0,
    CMD_ARM_LONG      = 4'd1,
    CMD_ARM_CYCLIC    = 4'd2,
    CMD_ARM_DOUBLE    = 4'd3,
    CMD_ARM_RELEASE   = 4'd4,
    CMD_CLEAR_LONG    = 4'd5,
    CMD_CLEAR_DOUBLE  = 4'd6,
    CMD_CLEAR_RELEASE = 4'd7,
    CMD_ACK           = 4'd8
  } cmd_t;

  // ms / TICK_MS by multiply with a rounded-up reciprocal. With the shift at
  // DUR_W + ceil(log2(TICK_MS)) the error term stays below one part in
  // TICK_MS, so the truncated quotient is exact for every DUR_W-bit value.
  localparam int TICK_SHIFT = DUR_W + $clog2(TICK_MS);
  localparam longint TICK_RECIP_L =
    ((longint'(1) << TICK_SHIFT) + longint'(TICK_MS) - 1) / longint'(TICK_MS);
  localparam logic [DUR_W:0] TICK_RECIP = (DUR_W+1)'(TICK_RECIP_L);

  localparam logic [DUR_W-1:0] DOUBLE_WINDOW_TICKS =
    DUR_W'(DOUBLE_WINDOW_MS / TICK_MS);

endpackage

// ===== rtl/ked_if.sv =====
// ----------------------------------------------------------------------------
// Key event detector channels
// Command channel and status channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ked_cmd_if;
  import ked_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key_code;
  logic [DUR_W-1:0] duration_ms;

  modport source (output valid, cmd, key_code, duration_ms, input ready);
  modport sink   (input valid, cmd, key_code, duration_ms, output ready);
endinterface

interface ked_status_if;
  import ked_pkg::*;

  logic             valid;
  logic             ready;
  logic             key_pending;
  logic [KEY_W-1:0] current_key;
  logic             long_status;
  logic             cyclic_status;
  logic             double_status;
  logic             release_status;

  modport source (output valid, key_pending, current_key, long_status, cyclic_status,
                  double_status, release_status, input ready);
  modport sink   (input valid, key_pending, current_key, long_status, cyclic_status,
                  double_status, release_status, output ready);
endinterface

// ===== rtl/key_event_detector.sv =====
// ----------------------------------------------------------------------------
// Key event detector
// Tracks a sampled key per tick and flags press, long press, cyclic repeat,
// double click and release events; one status transfer per command.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                   | handshake
//  ----------+-----+-------------------------------------------+-----------
//  request   | in  | cmd, key_code, duration_ms                | valid/ready
//  response  | out | key_pending, current_key, long_status,    | valid/ready
//            |     | cyclic_status, double_status, release_status
//
//  One command per cycle sustained while response is not stalled; a command
//  passes the input register, then the result register, to response valid.
//  The ms-to-tick multiply sits before the input register; the state update
//  is one pass of compares and decrements before the result register.
//  rst is synchronous: clears state, both valid flags and all armed modes.
//  A stall on response holds the result; the input register then fills and
//  request.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module key_event_detector (
  input  logic          clk,
  input  logic          rst,
  ked_cmd_if.sink       request,
  ked_status_if.source  response
);
  import ked_pkg::*;

  // Input register
  logic             s1_valid;
  cmd_t             s1_cmd;
  logic [KEY_W-1:0] s1_key;
  logic [DUR_W-1:0] s1_ticks;

  // Result register
  logic             out_valid;

  // Detector state
  logic [KEY_W-1:0] last_key,      last_key_next;
  logic [DUR_W-1:0] hold_count,    hold_count_next;
  logic [DUR_W-1:0] window_count,  window_count_next;
  logic             long_armed,    long_armed_next;
  logic             cyclic_armed,  cyclic_armed_next;
  logic             double_armed,  double_armed_next;
  logic             release_armed, release_armed_next;
  logic             long_fired,    long_fired_next;
  logic             cyclic_fired,  cyclic_fired_next;
  logic             double_seen,   double_seen_next;
  logic             release_seen,  release_seen_next;
  logic             key_held,      key_held_next;
  logic             pending_flag,  pending_flag_next;

  logic             out_free;
  logic             s1_advance;
  logic             in_xfer;
  logic [2*DUR_W:0] dur_prod;
  logic [DUR_W-1:0] dur_ticks;
  logic [DUR_W-1:0] hold_dec;

  // Result register frees when empty or when its transfer completes.
  assign out_free   = !out_valid || response.ready;
  assign s1_advance = s1_valid && out_free;
  assign request.ready = !s1_valid || s1_advance;
  assign in_xfer    = request.valid && request.ready;

  // Convert hold time to ticks on the way in.
  assign dur_prod  = {1'b0, request.duration_ms} * TICK_RECIP;
  assign dur_ticks = DUR_W'(dur_prod >> TICK_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload: load on transfer, no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd   <= cmd_t'(request.cmd);
      s1_key   <= request.key_code;
      s1_ticks <= dur_ticks;
    end
  end

  assign hold_dec = (hold_count != '0) ? hold_count - 1'b1 : hold_count;

  // One pass of the command over the state.
  always_comb begin
    last_key_next      = last_key;
    hold_count_next    = hold_count;
    window_count_next  = window_count;
    long_armed_next    = long_armed;
    cyclic_armed_next  = cyclic_armed;
    double_armed_next  = double_armed;
    release_armed_next = release_armed;
    long_fired_next    = long_fired;
    cyclic_fired_next  = cyclic_fired;
    double_seen_next   = double_seen;
    release_seen_next  = release_seen;
    key_held_next      = key_held;
    pending_flag_next  = pending_flag;

    unique case (s1_cmd)
      CMD_TICK: begin
        // Window counts down; an expired window disarms double click.
        if (window_count != '0) begin
          window_count_next = window_count - 1'b1;
        end else begin
          double_armed_next = 1'b0;
        end

        if (s1_key != '0) begin
          hold_count_next = hold_dec;
          if (s1_key == last_key) begin
            // Continued hold: long fires once, cyclic on every tick once the hold count has run out.
            if (long_armed && hold_dec == '0) begin
              if (!long_fired) begin
                pending_flag_next = 1'b1;
              end
              long_fired_next = 1'b1;
            end
            if (cyclic_armed && hold_dec == '0) begin
              pending_flag_next = 1'b1;
              cyclic_fired_next = 1'b1;
            end
          end else if (double_armed_next && window_count_next != '0) begin
            // New code inside an open window counts as a double click.
            pending_flag_next = 1'b1;
            double_seen_next  = 1'b1;
          end
          if (!key_held) begin
            pending_flag_next = 1'b1;
          end
          last_key_next     = s1_key;
          release_seen_next = 1'b0;
          key_held_next     = 1'b1;
        end else begin
          // Release: keep the code only when release reporting is armed.
          if (release_armed) begin
            if (key_held) begin
              pending_flag_next = 1'b1;
              release_seen_next = 1'b1;
            end
          end else begin
            last_key_next = '0;
          end
          cyclic_armed_next = 1'b0;
          long_armed_next   = 1'b0;
          long_fired_next   = 1'b0;
          cyclic_fired_next = 1'b0;
          double_seen_next  = 1'b0;
          key_held_next     = 1'b0;
        end
      end
      CMD_ARM_LONG: begin
        if (!long_armed) begin
          long_armed_next = 1'b1;
          hold_count_next = s1_ticks;
        end
      end
      CMD_ARM_CYCLIC: begin
        // Always reload; long and cyclic share the hold counter.
        cyclic_armed_next = 1'b1;
        hold_count_next   = s1_ticks;
      end
      CMD_ARM_DOUBLE: begin
        if (!double_armed) begin
          double_armed_next = 1'b1;
          window_count_next = DOUBLE_WINDOW_TICKS;
        end
      end
      CMD_ARM_RELEASE:   release_armed_next = 1'b1;
      CMD_CLEAR_LONG:    long_armed_next    = 1'b0;
      CMD_CLEAR_DOUBLE:  double_armed_next  = 1'b0;
      CMD_CLEAR_RELEASE: release_armed_next = 1'b0;
      CMD_ACK:           pending_flag_next  = 1'b0;
      default: begin
        // Unused codes leave the state alone.
      end
    endcase
  end

  // Commit the state when the command moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_key      <= '0;
      hold_count    <= '0;
      window_count  <= '0;
      long_armed    <= 1'b0;
      cyclic_armed  <= 1'b0;
      double_armed  <= 1'b0;
      release_armed <= 1'b0;
      long_fired    <= 1'b0;
      cyclic_fired  <= 1'b0;
      double_seen   <= 1'b0;
      release_seen  <= 1'b0;
      key_held      <= 1'b0;
      pending_flag  <= 1'b0;
    end else if (s1_advance) begin
      last_key      <= last_key_next;
      hold_count    <= hold_count_next;
      window_count  <= window_count_next;
      long_armed    <= long_armed_next;
      cyclic_armed  <= cyclic_armed_next;
      double_armed  <= double_armed_next;
      release_armed <= release_armed_next;
      long_fired    <= long_fired_next;
      cyclic_fired  <= cyclic_fired_next;
      double_seen   <= double_seen_next;
      release_seen  <= release_seen_next;
      key_held      <= key_held_next;
      pending_flag  <= pending_flag_next;
    end
  end

  // Result valid: set on advance, drop once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: snapshot of the state after the command.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      response.key_pending    <= pending_flag_next;
      response.current_key    <= last_key_next;
      response.long_status    <= long_fired_next;
      response.cyclic_status  <= cyclic_fired_next;
      response.double_status  <= double_seen_next;
      response.release_status <= release_seen_next;
    end
  end

  assign response.valid = out_valid;

endmodule

// ===== rtl/ked_checker.sv =====
// ----------------------------------------------------------------------------
// Key event detector checker
// Port-level assertions on handshake, occupancy and status consistency.
// ----------------------------------------------------------------------------
`include "key_event_detector_macros.svh"

module ked_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  rsp_pending,
  input logic [ked_pkg::KEY_W-1:0] rsp_key,
  input logic                  rsp_long,
  input logic                  rsp_cyclic,
  input logic                  rsp_double,
  input logic                  rsp_release
);
  import ked_pkg::*;

  // Commands taken but not yet answered: input and result register at most.
  logic [1:0] inflight;
  logic       req_xfer;
  logic       rsp_xfer;
  logic       rsp_stall;
  logic [KEY_W+4:0] rsp_payload;
  logic       release_clash;

  assign req_xfer  = req_valid && req_ready;
  assign rsp_xfer  = rsp_valid && rsp_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;

  assign rsp_payload   = {rsp_pending, rsp_key, rsp_long, rsp_cyclic, rsp_double, rsp_release};
  assign release_clash = rsp_valid && rsp_release && (rsp_long || rsp_cyclic || rsp_double);

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      inflight <= inflight + 1'b1;
    end else if (rsp_xfer && !req_xfer) begin
      inflight <= inflight - 1'b1;
    end
  end

  `KED_ASSERT_NEXT(a_rsp_valid_holds, rsp_stall, rsp_valid, "response valid dropped on stall")
  `KED_ASSERT_NEXT(a_rsp_payload_holds, rsp_stall, $stable(rsp_payload), "payload not held")
  `KED_ASSERT_ALWAYS(a_inflight_bound, inflight <= 2'd2, "more than two commands in flight")
  `KED_ASSERT_ALWAYS(a_no_orphan_rsp, !rsp_valid || inflight != 2'd0, "orphan response")
  `KED_ASSERT_ALWAYS(a_release_alone, !release_clash, "release status with hold status")

endmodule

bind key_event_detector ked_checker u_ked_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .rsp_valid   (response.valid),
  .rsp_ready   (response.ready),
  .rsp_pending (response.key_pending),
  .rsp_key     (response.current_key),
  .rsp_long    (response.long_status),
  .rsp_cyclic  (response.cyclic_status),
  .rsp_double  (response.double_status),
  .rsp_release (response.release_status)
);
